// ----- src/atr_pkg.sv -----
// shared types and constants for the averaged temperature reporter
`default_nettype none
package atr_pkg;

  localparam int SAMPLE_W = 12;
  localparam int WIN_W    = 4;
  localparam int DEG_W    = 10;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 4'd3;

  // q16 conversion constants: t = OFFSET - avg * SLOPE
  localparam logic [15:0] SLOPE_Q16  = 16'd45178;
  localparam logic [26:0] OFFSET_Q16 = 27'd104493200;
  localparam logic [DEG_W-1:0] TEMP_MAX = 10'd999;

  // x / 10 == (x * 205) >> 11 for x below 1024
  localparam logic [7:0] DIV10_MUL = 8'd205;

  localparam logic [7:0] MARK_BYTE  = 8'h59;
  localparam logic [7:0] DIGIT_BASE = 8'h30;

  localparam int NUM_DIGITS = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_MULTIPLY,
    ST_CONVERT,
    ST_DIGITS,
    ST_EMIT
  } atr_state_t;

  typedef struct packed {
    logic       accept;
    logic       div_step;
    logic       mul;
    logic       conv;
    logic       dig_step;
    logic [1:0] emit_idx;
  } atr_cmd_t;

  typedef struct packed {
    logic       report;
    logic [1:0] num_digits;
  } atr_status_t;

endpackage
`default_nettype wire

// ----- src/averaged_temperature_reporter.sv -----
// top level: averaging temperature reporter with stream ports and config port
// a sample that does not complete a window is added to the sum; s_tready stays high
// the sample that completes a window starts a report: SUM_W divide steps (15 at the
// default window limit), one multiply, one convert and three digit steps, then 2 to 4
// output bytes at one per cycle while m_tready is high; no sample is taken meanwhile
// synchronous reset clears the sum and count, sets window_length to 3, returns to idle
`default_nettype none
module averaged_temperature_reporter #(
  parameter int MAX_WINDOW = 8
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // [11:0] sample, [15:12] zero
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import atr_pkg::*;

  localparam int EFF_MAX = (MAX_WINDOW < 15) ? MAX_WINDOW : 15;
  localparam int SUM_W   = SAMPLE_W + $clog2(EFF_MAX);

  logic [WIN_W-1:0] window_length;
  atr_cmd_t         cmd;
  atr_status_t      status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      window_length <= pwdata[WIN_W-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {28'd0, window_length};

  atr_ctrl #(
    .SUM_W(SUM_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  atr_dp #(
    .MAX_WINDOW(MAX_WINDOW),
    .SUM_W     (SUM_W)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .sample        (s_tdata[SAMPLE_W-1:0]),
    .window_length (window_length),
    .cmd           (cmd),
    .status        (status),
    .out_byte      (m_tdata),
    .last          (m_tlast)
  );

endmodule
`default_nettype wire

// ----- src/atr_ctrl.sv -----
// controller state machine: sequences divide, multiply, convert, digit split and byte output
`default_nettype none
module atr_ctrl #(
  parameter int SUM_W = 15
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  wire                 m_tready,
  input  atr_pkg::atr_status_t status,
  output atr_pkg::atr_cmd_t   cmd
);
  import atr_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  atr_state_t       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       emit, emit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      emit  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      emit  <= emit_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    emit_next    = emit;
    s_tready     = 1'b0;
    m_tvalid     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.div_step = 1'b0;
    cmd.mul      = 1'b0;
    cmd.conv     = 1'b0;
    cmd.dig_step = 1'b0;
    cmd.emit_idx = emit;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid && status.report) begin
          state_next = ST_DIVIDE;
          cnt_next   = '0;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(SUM_W - 1)) begin
          state_next = ST_MULTIPLY;
        end
      end
      ST_MULTIPLY: begin
        cmd.mul    = 1'b1;
        state_next = ST_CONVERT;
      end
      ST_CONVERT: begin
        cmd.conv   = 1'b1;
        cnt_next   = '0;
        state_next = ST_DIGITS;
      end
      ST_DIGITS: begin
        cmd.dig_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(NUM_DIGITS - 1)) begin
          state_next = ST_EMIT;
          emit_next  = '0;
        end
      end
      ST_EMIT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (emit == status.num_digits) begin
            state_next = ST_IDLE;
          end else begin
            emit_next = emit + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/atr_dp.sv -----
// datapath: accumulator, serial divider, q16 conversion, decimal digit split
`default_nettype none
module atr_dp #(
  parameter int MAX_WINDOW = 8,
  parameter int SUM_W      = 15
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire  [atr_pkg::SAMPLE_W-1:0]        sample,
  input  wire  [atr_pkg::WIN_W-1:0]           window_length,
  input  atr_pkg::atr_cmd_t                  cmd,
  output atr_pkg::atr_status_t               status,
  output logic [7:0]                         out_byte,
  output logic                               last
);
  import atr_pkg::*;

  localparam int EFF_MAX = (MAX_WINDOW < 15) ? MAX_WINDOW : 15;
  localparam int PROD_W  = SUM_W + 16;

  logic [SUM_W-1:0]  sum;
  logic [WIN_W-1:0]  fill;
  logic [SUM_W-1:0]  sum_add;
  logic [WIN_W-1:0]  fill_inc;
  logic [WIN_W-1:0]  weff;
  logic              report;

  logic [SUM_W-1:0]  quot;
  logic [WIN_W-1:0]  rem;
  logic [WIN_W-1:0]  divisor;
  logic [WIN_W:0]    rem_sh;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] diff;
  logic [SUM_W-1:0]  deg_hi;
  logic [DEG_W-1:0]  deg_c;
  logic [1:0]        nd;

  logic [DEG_W-1:0]  work;
  logic [17:0]       prod10;
  logic [6:0]        q10;
  logic [DEG_W-1:0]  rem10;
  logic [3:0]        dig [NUM_DIGITS];
  logic [1:0]        sel;
  logic [3:0]        dsel;

  always_comb begin
    if (window_length == '0) begin
      weff = WIN_W'(1);
    end else if (window_length > WIN_W'(EFF_MAX)) begin
      weff = WIN_W'(EFF_MAX);
    end else begin
      weff = window_length;
    end
    sum_add  = sum + SUM_W'(sample);
    fill_inc = fill + 1'b1;
    report   = (fill_inc >= weff);
  end

  assign status.report     = report;
  assign status.num_digits = nd;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum  <= '0;
      fill <= '0;
    end else if (cmd.accept) begin
      if (report) begin
        sum  <= '0;
        fill <= '0;
      end else begin
        sum  <= sum_add;
        fill <= fill_inc;
      end
    end
  end

  // restoring divide, one quotient bit per step
  assign rem_sh = {rem, quot[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.accept && report) begin
      quot    <= sum_add;
      rem     <= '0;
      divisor <= weff;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem  <= WIN_W'(rem_sh - {1'b0, divisor});
        quot <= {quot[SUM_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[WIN_W-1:0];
        quot <= {quot[SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PROD_W'(quot) * PROD_W'(SLOPE_Q16);
    end
  end

  // negative result clamps to zero, large result to the top value
  always_comb begin
    diff   = PROD_W'(OFFSET_Q16) - prod;
    deg_hi = diff[PROD_W-1:16];
    if (prod > PROD_W'(OFFSET_Q16)) begin
      deg_c = '0;
    end else if (deg_hi > SUM_W'(TEMP_MAX)) begin
      deg_c = TEMP_MAX;
    end else begin
      deg_c = deg_hi[DEG_W-1:0];
    end
  end

  always_comb begin
    prod10 = 18'(work) * 18'(DIV10_MUL);
    q10    = prod10[17:11];
    rem10  = work - {q10, 3'b000} - {2'b00, q10, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (cmd.conv) begin
      work <= deg_c;
      if (deg_c >= DEG_W'(100)) begin
        nd <= 2'd3;
      end else if (deg_c >= DEG_W'(10)) begin
        nd <= 2'd2;
      end else begin
        nd <= 2'd1;
      end
    end else if (cmd.dig_step) begin
      // units come out first and end up in the lowest slot
      work   <= DEG_W'(q10);
      dig[2] <= rem10[3:0];
      dig[1] <= dig[2];
      dig[0] <= dig[1];
    end
  end

  always_comb begin
    sel = nd - cmd.emit_idx;
    case (sel)
      2'd0:    dsel = dig[0];
      2'd1:    dsel = dig[1];
      2'd2:    dsel = dig[2];
      default: dsel = dig[0];
    endcase
    if (cmd.emit_idx == 2'd0) begin
      out_byte = MARK_BYTE;
      last     = 1'b0;
    end else begin
      out_byte = DIGIT_BASE + {4'b0000, dsel};
      last     = (cmd.emit_idx == nd);
    end
  end

endmodule
`default_nettype wire

// ----- src/atr_checker.sv -----
// port-level checks for the temperature reporter, bound to the top level
`default_nettype none
module atr_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [7:0]  m_tdata,
  input wire        m_tlast
);
  import atr_pkg::*;

  // input side is closed while a report is being sent
  a_excl: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input ready while report bytes pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  // report bytes follow one another with no gap
  a_cont: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside a report");

  a_mark: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> m_tdata == MARK_BYTE && !m_tlast)
    else $error("report does not open with marker byte");

  a_back: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("input not reopened after last transfer");

endmodule

bind averaged_temperature_reporter atr_checker u_atr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire
